FILE: rtl/core/nearest_time_index_search_top_defines.svh
// Assertion macros shared by the checker of the nearest time index search block.
`ifndef NEAREST_TIME_INDEX_SEARCH_TOP_DEFINES_SVH
`define NEAREST_TIME_INDEX_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define NTIS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define NTIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ntis_pkg.sv
// Package with the types and constants of the nearest time index search block.
`timescale 1ns / 1ps

package ntis_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int POS_W       = IDX_W + 2;

    localparam int COUNT_W     = 11;
    localparam int ENTRY_W     = 10;
    localparam int TIME_W      = 64;
    localparam int NEAREST_W   = 10;
    localparam int S_DATA_W    = 80;
    localparam int M_DATA_W    = 16;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PCMP,
        S_C2,
        S_C3,
        S_C4,
        S_DONE
    } state_t;

endpackage

FILE: rtl/core/nearest_time_index_search_top.sv
// Top level of the nearest time index search block: time table and search sequencer.
`timescale 1ns / 1ps

// A request on the s_ channel either loads one row of the time table (tuser low) or
// queries the row nearest a Q32.32 key (tuser high). A load gives no result. A query
// runs a binary search in which every probe first reads the table memory and then
// compares the row with the key in the shared subtract and compare unit. When the
// range closes, up to three neighbouring rows (the third only if it lies below the
// entry count) are read one per cycle through the same unit. Over a full 1024-row
// table a query needs at most ten probes; exact hits and short tables end sooner.
// The result is held in an output register on the m_ channel; the block returns to
// idle and takes the next request while that result waits to be taken. If the
// receiver still stalls when the next query finishes, that query waits until the
// register is free. The entry count register is written over the cfg_ channel and
// is always ready. Reset clears the sequencer, the output valid and the entry count
// to zero; the table contents are undefined until rows are written, and no clearing
// pass runs.
module nearest_time_index_search_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_index [9:0], time_value [73:10], zero fill [79:74]
    input  logic [ntis_pkg::S_DATA_W-1:0] s_tdata,
    // mode [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // nearest_index [9:0], zero fill [15:10]
    output logic [ntis_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ntis_pkg::COUNT_W-1:0]  cfg_data
);
    import ntis_pkg::*;

    logic [TIME_W-1:0]       mem [TABLE_DEPTH];
    logic [TIME_W-1:0]       rdata_reg;

    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      entry_count_reg;
    logic signed [POS_W-1:0] low_reg, low_next;
    logic signed [POS_W-1:0] high_reg, high_next;
    logic signed [POS_W-1:0] n_reg, n_next;
    logic signed [POS_W-1:0] best_idx_reg, best_idx_next;
    logic signed [POS_W-1:0] result_reg, result_next;
    logic [TIME_W-1:0]       key_reg, key_next;
    logic [TIME_W-1:0]       best_reg, best_next;
    logic                    m_tvalid_reg;
    logic [NEAREST_W-1:0]    nearest_reg;

    logic [ENTRY_W-1:0]      s_entry_index;
    logic [TIME_W-1:0]       s_time_value;
    logic                    s_accept;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    out_load;

    logic signed [POS_W-1:0] mid;
    logic signed [POS_W-1:0] n_clamped;
    logic signed [TIME_W:0]  diff;
    logic                    key_below;
    logic [TIME_W-1:0]       row_gap;

    assign s_entry_index = s_tdata[ENTRY_W-1:0];
    assign s_time_value  = s_tdata[ENTRY_W+TIME_W-1:ENTRY_W];
    assign s_tready      = (state_reg == S_IDLE);
    assign s_accept      = s_tvalid && s_tready;
    assign cfg_ready     = 1'b1;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = {{(M_DATA_W-NEAREST_W){1'b0}}, nearest_reg};

    assign wr_en   = s_accept && (s_tuser == MODE_WRITE)
                     && (32'(s_entry_index) < TABLE_DEPTH);
    assign wr_addr = IDX_W'(s_entry_index);

    // Shared unit: subtractions give the ordering (65-bit) and absolute distance.
    assign mid       = (low_reg + high_reg) >>> 1;
    assign diff      = {key_reg[TIME_W-1], key_reg} - {rdata_reg[TIME_W-1], rdata_reg};
    assign key_below = diff[TIME_W];
    assign row_gap   = key_below ? (rdata_reg - key_reg) : diff[TIME_W-1:0];

    always_comb begin
        if (32'(entry_count_reg) > TABLE_DEPTH) begin
            n_clamped = POS_W'(TABLE_DEPTH);
        end else begin
            n_clamped = POS_W'(entry_count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_time_value;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                entry_count_reg <= cfg_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        low_reg      <= low_next;
        high_reg     <= high_next;
        n_reg        <= n_next;
        key_reg      <= key_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        result_reg   <= result_next;
        if (out_load) begin
            nearest_reg <= NEAREST_W'(result_reg);
        end
    end

    always_comb begin
        logic signed [POS_W-1:0] pick;
        pick          = best_idx_reg;
        state_next    = state_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        n_next        = n_reg;
        key_next      = key_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        result_next   = result_reg;
        rd_en         = 1'b0;
        rd_addr       = IDX_W'(mid);
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_accept && (s_tuser == MODE_QUERY)) begin
                    key_next   = s_time_value;
                    n_next     = n_clamped;
                    high_next  = n_clamped - POS_W'(1);
                    low_next   = '0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (high_reg <= 0) begin
                    result_next = '0;
                    state_next  = S_DONE;
                end else if (low_reg >= high_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(high_reg - POS_W'(1));
                    state_next = S_C2;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(mid);
                    state_next = S_PCMP;
                end
            end
            S_PCMP: begin
                if (diff == '0) begin
                    result_next = mid;
                    state_next  = S_DONE;
                end else begin
                    if (key_below) begin
                        high_next = mid - POS_W'(1);
                    end else begin
                        low_next = mid + POS_W'(1);
                    end
                    state_next = S_EVAL;
                end
            end
            S_C2: begin
                best_next     = row_gap;
                best_idx_next = high_reg - POS_W'(1);
                rd_en         = 1'b1;
                rd_addr       = IDX_W'(high_reg);
                state_next    = S_C3;
            end
            S_C3: begin
                if (!(best_reg < row_gap)) begin
                    best_next = row_gap;
                    pick      = high_reg;
                end
                best_idx_next = pick;
                if ((high_reg + POS_W'(1)) < n_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(high_reg + POS_W'(1));
                    state_next = S_C4;
                end else begin
                    result_next = pick;
                    state_next  = S_DONE;
                end
            end
            S_C4: begin
                if (best_reg < row_gap) begin
                    result_next = best_idx_reg;
                end else begin
                    result_next = high_reg + POS_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/ntis_checker.sv
// Port-level checker of the nearest time index search block, bound to its top level.
`timescale 1ns / 1ps
`include "nearest_time_index_search_top_defines.svh"

module ntis_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ntis_pkg::S_DATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ntis_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [ntis_pkg::COUNT_W-1:0]  cfg_data
);
    import ntis_pkg::*;

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    `NTIS_ASSERT_NEXT(a_out_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid,
        "result dropped while stalled")
    `NTIS_ASSERT_NEXT(a_data_held, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata),
        "result data changed while stalled")
    `NTIS_ASSERT_NEXT(a_query_busy, aclk, aresetn, s_acc && (s_tuser == MODE_QUERY),
        !s_tready, "query accepted without going busy")
    `NTIS_ASSERT_NEXT(a_write_idle, aclk, aresetn, s_acc && (s_tuser == MODE_WRITE),
        s_tready, "table write left the block busy")
    `NTIS_ASSERT_NOW(a_no_instant_result, aclk, aresetn, $rose(m_tvalid), !$past(s_acc),
        "result appeared right after a request")

endmodule

bind nearest_time_index_search_top ntis_checker u_ntis_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the nearest time index search block: table loads, queries and checks.
module tb;
    import ntis_pkg::*;

    localparam int SETTLE_CYCLES = 32;
    localparam logic signed [TIME_W-1:0] T_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [TIME_W-1:0] T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // entry_index [9:0], time_value [73:10], zero fill [79:74]
    logic [S_DATA_W-1:0]   s_tdata;
    // mode [0]
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // nearest_index [9:0], zero fill [15:10]
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_data;

    logic signed [TIME_W-1:0] time_rows [TABLE_DEPTH];
    logic [COUNT_W-1:0]       row_count;
    logic [NEAREST_W-1:0]     nearest_q [$];
    logic [NEAREST_W-1:0]     wanted_index;
    int                       send_idle_pct;
    int                       recv_idle_pct;
    int                       errors;

    nearest_time_index_search_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (nearest_q.size() == 0) begin
                $error("nearest_index: expected none, actual %0d", m_tdata[NEAREST_W-1:0]);
                errors++;
            end else begin
                wanted_index = nearest_q.pop_front();
                if (m_tdata[NEAREST_W-1:0] !== wanted_index) begin
                    $error("nearest_index: expected %0d, actual %0d",
                           wanted_index, m_tdata[NEAREST_W-1:0]);
                    errors++;
                end
            end
        end
    end

    function automatic logic [TIME_W-1:0] abs_gap(input logic signed [TIME_W-1:0] a,
                                                  input logic signed [TIME_W-1:0] b);
        return (a < b) ? b - a : a - b;
    endfunction

    function automatic logic [NEAREST_W-1:0] nearest_row(input logic signed [TIME_W-1:0] key);
        int               n;
        int               lo;
        int               hi;
        int               mid;
        bit               has_next;
        logic [TIME_W-1:0] d1;
        logic [TIME_W-1:0] d2;
        logic [TIME_W-1:0] d3;
        n  = (row_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(row_count);
        lo = 0;
        hi = n - 1;
        while (1) begin
            if (hi <= 0)
                return '0;
            if (lo >= hi) begin
                has_next = (hi + 1) < n;
                d1 = abs_gap(key, time_rows[hi-1]);
                d2 = abs_gap(key, time_rows[hi]);
                d3 = has_next ? abs_gap(key, time_rows[hi+1]) : d2;
                if (d1 < d2)
                    return NEAREST_W'((d1 < d3) ? hi - 1 : (has_next ? hi + 1 : hi));
                if (d2 < d3)
                    return NEAREST_W'(hi);
                return NEAREST_W'(has_next ? hi + 1 : hi);
            end
            mid = (lo + hi) / 2;
            if (key == time_rows[mid])
                return NEAREST_W'(mid);
            if (key < time_rows[mid])
                hi = mid - 1;
            else
                lo = mid + 1;
        end
    endfunction

    task automatic send_item(input logic mode, input logic [ENTRY_W-1:0] row,
                             input logic signed [TIME_W-1:0] value);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_DATA_W'({value, row});
        do @(posedge aclk); while (!s_tready);
        if (mode == MODE_WRITE)
            time_rows[row] = value;
        else
            nearest_q.push_back(nearest_row(value));
    endtask

    task automatic query(input logic signed [TIME_W-1:0] key);
        send_item(MODE_QUERY, ENTRY_W'($urandom), key);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_row_count(input logic [COUNT_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        row_count = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_rows(input int n, input bit sorted);
        logic signed [TIME_W-1:0] value;
        logic [TIME_W-1:0]        step_mask;
        step_mask = (64'd1 << $urandom_range(40)) - 64'd1;
        value     = $signed({$urandom, $urandom}) >>> 2;
        for (int i = 0; i < n; i++) begin
            if (!sorted)
                value = {$urandom, $urandom};
            send_item(MODE_WRITE, ENTRY_W'(i), value);
            value = value + ({$urandom, $urandom} & step_mask);
        end
    endtask

    function automatic logic signed [TIME_W-1:0] pick_key(input int n);
        int                       k;
        logic signed [TIME_W-1:0] offset;
        if (n < 2)
            return {$urandom, $urandom};
        k = $urandom_range(n - 1);
        case ($urandom_range(9))
            0, 1, 2, 3: return time_rows[k];
            4, 5, 6: begin
                offset = $urandom_range(2000);
                offset = (offset - 1000) <<< $urandom_range(40);
                return time_rows[k] + offset;
            end
            7:       return (time_rows[k] >>> 1) + (time_rows[(k + 1) % n] >>> 1);
            8:       return {$urandom, $urandom};
            default: return $urandom_range(1) ? T_MAX : T_MIN;
        endcase
    endfunction

    task automatic test_short_tables();
        query(T_MIN);
        query(T_MAX);
        drain_results();
        set_row_count(0);
        send_item(MODE_WRITE, 0, T_MIN);
        send_item(MODE_WRITE, ENTRY_W'(TABLE_DEPTH - 1), T_MAX);
        query(64'sd0);
        drain_results();
        set_row_count(1);
        query(T_MAX);
        query(T_MIN);
    endtask

    task automatic test_closing_compare();
        drain_results();
        set_row_count(2);
        send_item(MODE_WRITE, 1, T_MAX);
        query(T_MIN);
        query(T_MAX);
        query(64'sd0);
        query(-64'sd1);
        drain_results();
        set_row_count(3);
        send_item(MODE_WRITE, 0, 64'sd0);
        send_item(MODE_WRITE, 1, 64'sh0000_000A_0000_0000);
        send_item(MODE_WRITE, 2, 64'sh0000_0014_0000_0000);
        query(64'sh0000_0005_0000_0000);
        query(64'sh0000_000F_0000_0000);
        query(64'sh0000_000A_0000_0000);
        query(64'sh0000_0019_0000_0000);
        query(-64'sh0000_0005_0000_0000);
        query(64'sh0000_0014_0000_0000);
    endtask

    task automatic test_full_table();
        drain_results();
        set_row_count(COUNT_W'(TABLE_DEPTH));
        load_rows(TABLE_DEPTH, 1'b1);
        for (int i = 0; i < 20; i++)
            query(pick_key(TABLE_DEPTH));
        drain_results();
        set_row_count('1);
        query(T_MIN);
        query(T_MAX);
        for (int i = 0; i < 8; i++)
            query(pick_key(TABLE_DEPTH));
        drain_results();
        set_row_count(1100);
        for (int i = 0; i < 5; i++)
            query(pick_key(TABLE_DEPTH));
    endtask

    task automatic test_random_tables(input int item_goal);
        int sent;
        int n;
        int noise;
        int queries;
        sent = 0;
        while (sent < item_goal) begin
            drain_results();
            case ($urandom_range(9))
                0:       n = $urandom_range(3);
                1:       n = $urandom_range(130, 41);
                default: n = $urandom_range(40, 2);
            endcase
            set_row_count(COUNT_W'(n));
            load_rows(n, $urandom_range(7) != 0);
            noise = $urandom_range(2);
            for (int i = 0; i < noise; i++)
                send_item(MODE_WRITE, ENTRY_W'($urandom_range(TABLE_DEPTH - 1, n)),
                          {$urandom, $urandom});
            queries = $urandom_range(16, 6);
            for (int i = 0; i < queries; i++)
                query(pick_key(n));
            sent += n + noise + queries;
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        row_count     = '0;
        errors        = 0;
        send_idle_pct = 31;
        recv_idle_pct = 62;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_short_tables();
        test_closing_compare();
        test_full_table();
        test_random_tables(170);
        drain_results();
        send_idle_pct = 62;
        recv_idle_pct = 31;
        test_random_tables(170);
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_tables(170);
        drain_results();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: nearest_time_index_search_top.f
+incdir+rtl/core
rtl/core/ntis_pkg.sv
rtl/core/nearest_time_index_search_top.sv
rtl/core/ntis_checker.sv
test/tb.sv
